// ----- hw/rtl/gmpb_pkg.sv -----
package gmpb_pkg;

   // plane store geometry
   localparam int MAX_WIDTH = 256;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROWS      = 8;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int LANE_W    = 3;
   localparam int ENTRY_W   = ROWS * LANE_W;

   // result queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // sample and config widths
   localparam int SAMPLE_W = 16;
   localparam int GEOM_W   = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_MAX     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_MAX     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 4'd3;

   localparam logic [SAMPLE_W-1:0] GRAY_MAX_RST     = 16'd255;
   localparam logic [SAMPLE_W-1:0] MASK_MAX_RST     = 16'd255;
   localparam logic [GEOM_W-1:0]   IMAGE_WIDTH_RST  = 8'd128;
   localparam logic [GEOM_W-1:0]   IMAGE_HEIGHT_RST = 8'd64;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // plane codes double as the bit position inside a lane
   localparam logic [1:0] PLANE_LSB  = 2'd0;
   localparam logic [1:0] PLANE_MSB  = 2'd1;
   localparam logic [1:0] PLANE_MASK = 2'd2;

   typedef enum logic [1:0] {
      ST_ACCEPT    = 2'd0,
      ST_PAGE_DONE = 2'd1,
      ST_REFUSED   = 2'd2,
      ST_PULL      = 2'd3
   } status_type;

   // classified transaction handed from front to back
   typedef struct packed {
      status_type          status;
      logic                byte_valid;
      logic [1:0]          plane;
      logic [COL_W-1:0]    column;
      logic                last_of_page;
      logic                last_of_image;
   } desc_type;

   typedef struct packed {
      status_type          status;
      logic                byte_valid;
      logic [7:0]          data_byte;
      logic [1:0]          plane;
      logic [COL_W-1:0]    column;
      logic                last_of_page;
      logic                last_of_image;
   } rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic [ROW_W-1:0]    wr_lane;
      logic [COL_W-1:0]    wr_addr;
      logic [LANE_W-1:0]   wr_data;
      logic                rd_en;
      logic [COL_W-1:0]    rd_addr;
   } ram_cmd_type;

endpackage

// ----- hw/rtl/gray_mask_to_page_bitplanes.sv -----
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser opcode; tdata pixel_value, mask_value
// rsp      out  rsp_tvalid/rsp_tready  tuser status; tlast last_of_page; tdata rest
// csr      in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One transaction per cycle sustained while req_tready is high; each request passes
// the in-flight stage, fed by the registered read of the column plane memory.
// A four-entry result queue decouples the sides; req_tready drops only when
// the queue plus the in-flight stage are full.
// Reset clears control state and the queue; the plane memory is not cleared.
module gray_mask_to_page_bitplanes
   import gmpb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,   // [0] opcode
   input  logic [31:0]            req_tdata,   // [15:0] pixel_value, [31:16] mask_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [1:0]             rsp_tuser,   // [1:0] status
   output logic                   rsp_tlast,   // last_of_page
   // [0] byte_valid, [8:1] data_byte, [10:9] plane, [18:11] column,
   // [19] last_of_image, [23:20] zero
   output logic [23:0]            rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic                space_ok;
   logic                desc_valid;
   desc_type            desc;
   ram_cmd_type         ram_cmd;
   logic [ENTRY_W-1:0]  rd_data;
   rsp_type             rsp_head;

   gmpb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .space_ok   (space_ok),
      .desc_valid (desc_valid),
      .desc       (desc),
      .ram_cmd    (ram_cmd)
   );

   gmpb_plane_ram u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (rd_data)
   );

   gmpb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc       (desc),
      .rd_data    (rd_data),
      .space_ok   (space_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_head   (rsp_head)
   );

   assign rsp_tuser = rsp_head.status;
   assign rsp_tlast = rsp_head.last_of_page;
   assign rsp_tdata = {4'b0000, rsp_head.last_of_image, rsp_head.column,
                       rsp_head.plane, rsp_head.data_byte, rsp_head.byte_valid};

endmodule

// ----- hw/rtl/gmpb_plane_ram.sv -----
module gmpb_plane_ram
   import gmpb_pkg::*;
(
   input  logic                clock,
   input  ram_cmd_type         cmd,
   output logic [ENTRY_W-1:0]  rd_data
);

   // one entry per column, one lane of three plane bits per row
   logic [ENTRY_W-1:0] mem_ff [MAX_WIDTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROWS; i++) begin
         if (cmd.wr_en && (cmd.wr_lane == ROW_W'(i))) begin
            mem_ff[cmd.wr_addr][i*LANE_W +: LANE_W] <= cmd.wr_data;
         end else if (cmd.wr_en && (cmd.wr_lane == '0)) begin
            // first row of a page starts the column entry fresh
            mem_ff[cmd.wr_addr][i*LANE_W +: LANE_W] <= '0;
         end
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/gmpb_front.sv -----
module gmpb_front
   import gmpb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   input  logic [31:0]            req_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   space_ok,
   output logic                   desc_valid,
   output desc_type               desc,
   output ram_cmd_type            ram_cmd
);

   logic [SAMPLE_W-1:0] gray_max_ff, gray_max_in;
   logic [SAMPLE_W-1:0] mask_max_ff, mask_max_in;
   logic [GEOM_W-1:0]   image_width_ff, image_width_in;
   logic [GEOM_W-1:0]   image_height_ff, image_height_in;
   logic [GEOM_W-1:0]   row_index_ff, row_index_in;
   logic [COL_W-1:0]    column_index_ff, column_index_in;
   logic                page_pending_ff, page_pending_in;
   logic                final_page_ff, final_page_in;
   logic [1:0]          drain_plane_ff, drain_plane_in;
   logic [COL_W-1:0]    drain_column_ff, drain_column_in;

   logic                accept;
   logic [SAMPLE_W-1:0] pixel_value;
   logic [SAMPLE_W-1:0] mask_value;
   logic [GEOM_W-1:0]   w_eff, h_eff;
   logic [COL_W-1:0]    col;
   logic [GEOM_W-1:0]   row;
   logic                col_last, row_last, page_done;
   logic [ROW_W-1:0]    row_bit;
   logic [17:0]         gray_x3;
   logic [SAMPLE_W-1:0] thr_q1, thr_q2, thr_q3;
   logic [1:0]          level;
   logic                mask_bit;
   logic [1:0]          drain_pl;
   logic                drain_last;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = space_ok;
   assign csr_ready   = 1'b1;
   assign pixel_value = req_tdata[15:0];
   assign mask_value  = req_tdata[31:16];

   assign w_eff = (image_width_ff == '0) ? GEOM_W'(1) : image_width_ff;
   assign h_eff = (image_height_ff == '0) ? GEOM_W'(1) : image_height_ff;

   // wrap stale positions after a geometry change
   assign col = ({1'b0, column_index_ff} >= {1'b0, w_eff}) ? '0 : column_index_ff;
   assign row = (row_index_ff >= h_eff) ? '0 : row_index_ff;

   assign col_last  = ({1'b0, col} + 9'd1) >= {1'b0, w_eff};
   assign row_last  = ({1'b0, row} + 9'd1) >= {1'b0, h_eff};
   assign row_bit   = row[ROW_W-1:0];
   assign page_done = col_last && ((row_bit == ROW_W'(ROWS - 1)) || row_last);

   assign gray_x3 = {2'b00, gray_max_ff} + {1'b0, gray_max_ff, 1'b0};
   assign thr_q1  = {2'b00, gray_max_ff[15:2]};
   assign thr_q2  = {1'b0, gray_max_ff[15:1]};
   assign thr_q3  = gray_x3[17:2];

   // inverted level: dark samples give the high code
   always_comb begin
      if (pixel_value < thr_q1) begin
         level = 2'd3;
      end else if (pixel_value < thr_q2) begin
         level = 2'd2;
      end else if (pixel_value < thr_q3) begin
         level = 2'd1;
      end else begin
         level = 2'd0;
      end
   end

   assign mask_bit = mask_value > {1'b0, mask_max_ff[15:1]};

   assign drain_pl   = (drain_plane_ff >= PLANE_MASK) ? PLANE_MASK : drain_plane_ff;
   assign drain_last = ({1'b0, drain_column_ff} + 9'd1) >= {1'b0, w_eff};

   always_comb begin
      gray_max_in     = gray_max_ff;
      mask_max_in     = mask_max_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      row_index_in    = row_index_ff;
      column_index_in = column_index_ff;
      page_pending_in = page_pending_ff;
      final_page_in   = final_page_ff;
      drain_plane_in  = drain_plane_ff;
      drain_column_in = drain_column_ff;
      desc            = '0;
      ram_cmd         = '0;

      if (accept) begin
         if (req_tuser == OP_PULL) begin
            desc.status = ST_PULL;
            if (page_pending_ff) begin
               desc.byte_valid    = 1'b1;
               desc.plane         = drain_pl;
               desc.column        = drain_column_ff;
               desc.last_of_page  = (drain_pl == PLANE_MASK) && drain_last;
               desc.last_of_image = final_page_ff;
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = drain_column_ff;
               if (drain_last) begin
                  drain_column_in = '0;
                  if (drain_pl == PLANE_MASK) begin
                     page_pending_in = 1'b0;
                     drain_plane_in  = PLANE_LSB;
                  end else begin
                     drain_plane_in = drain_pl + 2'd1;
                  end
               end else begin
                  drain_column_in = drain_column_ff + COL_W'(1);
               end
            end
         end else if (page_pending_ff) begin
            desc.status = ST_REFUSED;
         end else begin
            desc.status     = ST_ACCEPT;
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_lane = row_bit;
            ram_cmd.wr_addr = col;
            ram_cmd.wr_data = {mask_bit, level[1], level[0]};
            if (col_last) begin
               column_index_in = '0;
               row_index_in    = row_last ? '0 : row + GEOM_W'(1);
               if (page_done) begin
                  desc.status        = ST_PAGE_DONE;
                  desc.last_of_image = row_last;
                  final_page_in      = row_last;
                  page_pending_in    = 1'b1;
                  drain_plane_in     = PLANE_LSB;
                  drain_column_in    = '0;
               end
            end else begin
               column_index_in = col + COL_W'(1);
            end
         end
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRAY_MAX:     gray_max_in     = csr_data;
            CSR_MASK_MAX:     mask_max_in     = csr_data;
            CSR_IMAGE_WIDTH:  image_width_in  = csr_data[GEOM_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_data[GEOM_W-1:0];
            default: ;
         endcase
      end
   end

   assign desc_valid = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         gray_max_ff     <= GRAY_MAX_RST;
         mask_max_ff     <= MASK_MAX_RST;
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         row_index_ff    <= '0;
         column_index_ff <= '0;
         page_pending_ff <= 1'b0;
         final_page_ff   <= 1'b0;
         drain_plane_ff  <= PLANE_LSB;
         drain_column_ff <= '0;
      end else begin
         gray_max_ff     <= gray_max_in;
         mask_max_ff     <= mask_max_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         row_index_ff    <= row_index_in;
         column_index_ff <= column_index_in;
         page_pending_ff <= page_pending_in;
         final_page_ff   <= final_page_in;
         drain_plane_ff  <= drain_plane_in;
         drain_column_ff <= drain_column_in;
      end
   end

endmodule

// ----- hw/rtl/gmpb_back.sv -----
module gmpb_back
   import gmpb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                desc_valid,
   input  desc_type            desc,
   input  logic [ENTRY_W-1:0]  rd_data,
   output logic                space_ok,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output rsp_type             rsp_head
);

   logic                s1_valid_ff;
   desc_type            s1_ff;
   rsp_type             q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]  count_ff, count_in;
   logic [ROWS-1:0]     sel_bits;
   rsp_type             fmt;
   logic                push, pop;

   // pick the requested plane out of every row lane
   always_comb begin
      for (int i = 0; i < ROWS; i++) begin
         case (s1_ff.plane)
            PLANE_LSB:  sel_bits[i] = rd_data[i*LANE_W + 0];
            PLANE_MSB:  sel_bits[i] = rd_data[i*LANE_W + 1];
            PLANE_MASK: sel_bits[i] = rd_data[i*LANE_W + 2];
            default:    sel_bits[i] = 1'b0;
         endcase
      end
      fmt.status        = s1_ff.status;
      fmt.byte_valid    = s1_ff.byte_valid;
      fmt.data_byte     = sel_bits & {ROWS{s1_ff.byte_valid}};
      fmt.plane         = s1_ff.plane;
      fmt.column        = s1_ff.column;
      fmt.last_of_page  = s1_ff.last_of_page;
      fmt.last_of_image = s1_ff.last_of_image;
   end

   assign push       = s1_valid_ff;
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_head   = q_ff[rd_ptr_ff];

   // count the stage in flight so the queue never overflows
   assign space_ok = (count_ff + Q_CNT_W'(s1_valid_ff)) < Q_CNT_W'(Q_DEPTH);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= desc_valid;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_valid) begin
         s1_ff <= desc;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= fmt;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (count_ff == Q_CNT_W'(Q_DEPTH))) |-> pop)
      else $error("result written into a full queue");

   a_byte_on_pull: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_head.byte_valid) |-> (rsp_head.status == ST_PULL))
      else $error("packed byte delivered on a non-pull transaction");

endmodule
